FILE: rtl/core/rs485hd_pkg.sv
// Package: types, constants and codes shared by the RS485 half-duplex FIFO controller.
`default_nettype none
package rs485hd_pkg;

	localparam int FIFO_DEPTH = 64;
	localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW = $clog2(FIFO_DEPTH + 1);
	localparam int FILL_W = 7;

	typedef logic [AW-1:0] addr_t;
	typedef logic [CW-1:0] count_t;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_EVENT = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
		logic       rx_ready;
		logic       tx_empty;
		logic       tx_done;
	} item_t;

	typedef struct packed {
		logic              accepted;
		logic              read_valid;
		logic              tx_valid;
		logic              driving;
		logic [FILL_W-1:0] fill_level;
	} res_t;

	typedef struct packed {
		logic       we;
		addr_t      waddr;
		logic [7:0] wdata;
		logic       re;
		addr_t      raddr;
	} mem_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/rs485hd_if.sv
// Interfaces: input word channel and result word channel.
`default_nettype none
interface rs485hd_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] data;
	logic       rx_ready;
	logic       tx_empty;
	logic       tx_done;

	modport source (output valid, op, data, rx_ready, tx_empty, tx_done, input ready);
	modport sink (input valid, op, data, rx_ready, tx_empty, tx_done, output ready);
endinterface

interface rs485hd_result_if;
	logic       valid;
	logic       ready;
	logic       accepted;
	logic [7:0] read_data;
	logic       read_valid;
	logic [7:0] tx_data;
	logic       tx_valid;
	logic       driving;
	logic [6:0] fill_level;

	modport source (output valid, accepted, read_data, read_valid, tx_data, tx_valid,
		driving, fill_level, input ready);
	modport sink (input valid, accepted, read_data, read_valid, tx_data, tx_valid,
		driving, fill_level, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rs485hd_mem.sv
// FIFO byte store: one write port and one registered read port.
`default_nettype none
module rs485hd_mem
	import rs485hd_pkg::*;
(
	input  wire logic     clk,
	input  wire mem_cmd_t cmd,
	output logic [7:0]    rdata
);

	logic [7:0] mem [FIFO_DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[cmd.waddr] <= cmd.wdata;
		end
		if (cmd.re) begin
			rdata_q <= mem[cmd.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/core/rs485hd_ctrl.sv
// Direction mode, completion flags, FIFO pointers and per-word decisions.
`default_nettype none
module rs485hd_ctrl
	import rs485hd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  adv,
	input  wire item_t item,
	output res_t       res,
	output mem_cmd_t   cmd
);

	logic   tx_mode_q, empty_arm_q, done_arm_q;
	addr_t  head_q, tail_q;
	count_t count_q;

	logic   tx_mode_d, empty_arm_d, done_arm_d;
	logic   push, pop, accepted, read_valid, tx_valid;
	logic   full, empty, fire, push_rx;
	count_t count_d;
	logic [CW+FILL_W-1:0] count_ext;

	assign full  = (count_q == count_t'(FIFO_DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		tx_mode_d   = tx_mode_q;
		empty_arm_d = empty_arm_q;
		done_arm_d  = done_arm_q;
		push        = 1'b0;
		pop         = 1'b0;
		accepted    = 1'b0;
		read_valid  = 1'b0;
		tx_valid    = 1'b0;
		push_rx     = 1'b0;
		fire        = 1'b0;
		case (op_t'(item.op))
			OP_WRITE: begin
				if (tx_mode_q ? !full : empty) begin
					tx_mode_d   = 1'b1;
					empty_arm_d = 1'b1;
					push        = 1'b1;
					accepted    = 1'b1;
				end
			end
			OP_READ: begin
				if (!tx_mode_q && !empty) begin
					pop        = 1'b1;
					read_valid = 1'b1;
				end
			end
			OP_EVENT: begin
				push_rx = item.rx_ready && !tx_mode_q && !full;
				push    = push_rx;
				fire    = (item.tx_empty && empty_arm_q) || (item.tx_done && done_arm_q);
				if (fire) begin
					if (tx_mode_q && !empty) begin
						pop         = 1'b1;
						tx_valid    = 1'b1;
						done_arm_d  = 1'b0;
						empty_arm_d = 1'b1;
					end else begin
						empty_arm_d = 1'b0;
						if (item.tx_done) begin
							done_arm_d = 1'b0;
							tx_mode_d  = 1'b0;
						end else begin
							done_arm_d = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		count_d = count_q;
		if (push) begin
			count_d = count_q + count_t'(1);
		end else if (pop) begin
			count_d = count_q - count_t'(1);
		end
	end

	function automatic addr_t next_ptr(input addr_t p);
		next_ptr = (p == addr_t'(FIFO_DEPTH - 1)) ? '0 : p + addr_t'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_mode_q   <= 1'b0;
			empty_arm_q <= 1'b0;
			done_arm_q  <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
		end else if (adv) begin
			tx_mode_q   <= tx_mode_d;
			empty_arm_q <= empty_arm_d;
			done_arm_q  <= done_arm_d;
			count_q     <= count_d;
			if (push) begin
				tail_q <= next_ptr(tail_q);
			end
			if (pop) begin
				head_q <= next_ptr(head_q);
			end
		end
	end

	assign cmd.we    = adv && push;
	assign cmd.waddr = tail_q;
	assign cmd.wdata = item.data;
	assign cmd.re    = adv && pop;
	assign cmd.raddr = head_q;

	assign count_ext      = {{FILL_W{1'b0}}, count_d};
	assign res.accepted   = accepted;
	assign res.read_valid = read_valid;
	assign res.tx_valid   = tx_valid;
	assign res.driving    = tx_mode_d;
	assign res.fill_level = count_ext[FILL_W-1:0];

endmodule
`default_nettype wire

FILE: rtl/core/rs485_half_duplex_fifo_control_core.sv
// Top level: RS485 half-duplex direction control with one shared byte FIFO.
// Each word is a host write, a host read or a line event and yields exactly one result
// word. One word is accepted every cycle while the result channel is not stalled; a result
// passes through the input register, then the result register fed by the control logic and
// the FIFO memory's registered read port. A waiting result holds the result register while
// the input register takes one more word. No clearing pass runs after reset.
`default_nettype none
module rs485_half_duplex_fifo_control_core
	import rs485hd_pkg::*;
(
	input wire logic         clk,
	input wire logic         arst_n,
	rs485hd_item_if.sink     item,
	rs485hd_result_if.source result
);

	logic     valid_s1, valid_s2, adv;
	item_t    item_s1;
	res_t     res, res_s2;
	mem_cmd_t cmd;
	logic [7:0] rdata;

	assign adv        = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= '{op: item.op, data: item.data, rx_ready: item.rx_ready,
				tx_empty: item.tx_empty, tx_done: item.tx_done};
		end
	end

	rs485hd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.res    (res),
		.cmd    (cmd)
	);

	rs485hd_mem u_mem (
		.clk   (clk),
		.cmd   (cmd),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign result.valid      = valid_s2;
	assign result.accepted   = res_s2.accepted;
	assign result.read_valid = res_s2.read_valid;
	assign result.read_data  = res_s2.read_valid ? rdata : 8'h00;
	assign result.tx_valid   = res_s2.tx_valid;
	assign result.tx_data    = res_s2.tx_valid ? rdata : 8'h00;
	assign result.driving    = res_s2.driving;
	assign result.fill_level = res_s2.fill_level;

	a_one_pop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.read_valid && res_s2.tx_valid))
		else $error("read and transmit pop in the same word");

	a_write_drives: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.accepted) |-> res_s2.driving)
		else $error("accepted write left receive mode");

	a_read_rx: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.read_valid) |-> !res_s2.driving)
		else $error("host read served while driving");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !result.ready) |=> (valid_s2 && $stable(res_s2)))
		else $error("result register changed while stalled");

endmodule
`default_nettype wire
